/* rtl/core/cbf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cbf_pkg;

   localparam logic [1:0] MODE_MOVE  = 2'd0;
   localparam logic [1:0] MODE_LINE  = 2'd1;
   localparam logic [1:0] MODE_CUBIC = 2'd2;
   localparam logic [1:0] MODE_CLOSE = 2'd3;

   localparam logic [1:0] CSR_SEGMENT_LENGTH = 2'd0;
   localparam logic [1:0] CSR_MIN_SEGMENTS   = 2'd1;
   localparam logic [1:0] CSR_MAX_SEGMENTS   = 2'd2;

   localparam int SEG_LEN_WIDTH = 31;
   localparam int COUNT_WIDTH   = 7;
   localparam int CSR_WIDTH     = 31;

   localparam logic [SEG_LEN_WIDTH-1:0] SEG_LEN_RESET = 31'd524288;
   localparam logic [COUNT_WIDTH-1:0]   MIN_SEG_RESET = 7'd4;
   localparam logic [COUNT_WIDTH-1:0]   MAX_SEG_RESET = 7'd48;

   typedef struct packed {
      logic load;
      logic emit_err;
      logic emit_target;
      logic do_close;
      logic leg_start;
      logic leg_diff;
      logic sq_x;
      logic sq_y;
      logic root_step;
      logic leg_acc;
      logic cnt_init;
      logic cnt_step;
      logic w1;
      logic w2;
      logic mac;
      logic div_init;
      logic div_step;
      logic emit_curve;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       active;
      logic       out_free;
      logic       root_done;
      logic       leg_last;
      logic       cnt_done;
      logic       mac_last;
      logic       div_done;
      logic       pt_last;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/core/cbf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbf_ctrl
   import cbf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [14:0] {
      ST_IDLE     = 15'b000000000000001,
      ST_DECODE   = 15'b000000000000010,
      ST_LEG_DIFF = 15'b000000000000100,
      ST_LEG_SQX  = 15'b000000000001000,
      ST_LEG_SQY  = 15'b000000000010000,
      ST_LEG_ROOT = 15'b000000000100000,
      ST_LEG_ACC  = 15'b000000001000000,
      ST_CNT_INIT = 15'b000000010000000,
      ST_CNT_STEP = 15'b000000100000000,
      ST_PT_W1    = 15'b000001000000000,
      ST_PT_W2    = 15'b000010000000000,
      ST_PT_MAC   = 15'b000100000000000,
      ST_PT_DIVI  = 15'b001000000000000,
      ST_PT_DIV   = 15'b010000000000000,
      ST_PT_EMIT  = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.mode != MODE_MOVE && !sts.active) begin
               if (sts.out_free) begin
                  cmd.emit_err = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (sts.mode == MODE_MOVE || sts.mode == MODE_LINE) begin
               if (sts.out_free) begin
                  cmd.emit_target = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else if (sts.mode == MODE_CLOSE) begin
               cmd.do_close = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.leg_start = 1'b1;
               state_in      = ST_LEG_DIFF;
            end
         end
         ST_LEG_DIFF: begin
            cmd.leg_diff = 1'b1;
            state_in     = ST_LEG_SQX;
         end
         ST_LEG_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = ST_LEG_SQY;
         end
         ST_LEG_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = ST_LEG_ROOT;
         end
         ST_LEG_ROOT: begin
            cmd.root_step = 1'b1;
            if (sts.root_done) state_in = ST_LEG_ACC;
         end
         ST_LEG_ACC: begin
            cmd.leg_acc = 1'b1;
            state_in    = sts.leg_last ? ST_CNT_INIT : ST_LEG_DIFF;
         end
         ST_CNT_INIT: begin
            cmd.cnt_init = 1'b1;
            state_in     = ST_CNT_STEP;
         end
         ST_CNT_STEP: begin
            cmd.cnt_step = 1'b1;
            if (sts.cnt_done) state_in = ST_PT_W1;
         end
         ST_PT_W1: begin
            cmd.w1   = 1'b1;
            state_in = ST_PT_W2;
         end
         ST_PT_W2: begin
            cmd.w2   = 1'b1;
            state_in = ST_PT_MAC;
         end
         ST_PT_MAC: begin
            cmd.mac = 1'b1;
            if (sts.mac_last) state_in = ST_PT_DIVI;
         end
         ST_PT_DIVI: begin
            cmd.div_init = 1'b1;
            state_in     = ST_PT_DIV;
         end
         ST_PT_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_PT_EMIT;
         end
         ST_PT_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_curve = 1'b1;
               state_in       = sts.pt_last ? ST_IDLE : ST_PT_W1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/cbf_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbf_datapath
   import cbf_pkg::*;
#(
   parameter int CW            = 32,
   parameter int SEGMENT_LIMIT = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output sts_type                   sts,
   input  wire logic [1:0]           req_mode,
   input  wire logic                 req_relative,
   input  wire logic signed [31:0]   req_ctrl1_x,
   input  wire logic signed [31:0]   req_ctrl1_y,
   input  wire logic signed [31:0]   req_ctrl2_x,
   input  wire logic signed [31:0]   req_ctrl2_y,
   input  wire logic signed [31:0]   req_target_x,
   input  wire logic signed [31:0]   req_target_y,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [31:0]        rsp_point_x,
   output logic signed [31:0]        rsp_point_y,
   output logic                      rsp_status,
   output logic                      rsp_last,
   input  wire logic                 csr_write_enable,
   input  wire logic [1:0]           csr_index,
   input  wire logic [CSR_WIDTH-1:0] csr_write_data
);

   localparam int IW  = 32;
   localparam int BW  = (CW > IW) ? CW : IW;
   localparam int SW  = BW + 1;
   localparam int XW  = ((CW + 1) > 31) ? (CW + 1) : 31;
   localparam int LW  = BW + 5;
   localparam int PW  = ((LW > 38) ? LW : 38) + 1;
   localparam int KW  = COUNT_WIDTH;
   localparam int WW  = 19;
   localparam int AW  = CW + 22;
   localparam int NW  = CW + 24;
   localparam int DCW = $clog2(NW);
   localparam int OW  = (CW < IW) ? CW : IW;

   localparam logic signed [SW-1:0] CMAX_S = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] CMIN_S = -CMAX_S - SW'(1);
   localparam logic signed [NW:0]   OMAX_S = (NW+1)'((64'sd1 <<< (OW - 1)) - 64'sd1);
   localparam logic signed [NW:0]   OMIN_S = -OMAX_S - (NW+1)'(1);
   localparam logic [KW-1:0]        SEG_MAX = KW'(SEGMENT_LIMIT);
   localparam logic [DCW-1:0]       DIV_LAST = DCW'(NW - 1);

   function automatic logic signed [CW-1:0] abs_coord(input logic signed [31:0] v,
                                                      input logic signed [CW-1:0] o);
      logic signed [SW-1:0] s;
      s = $signed({{(SW-IW){v[IW-1]}}, v}) + $signed({{(SW-CW){o[CW-1]}}, o});
      if (s > CMAX_S) return CMAX_S[CW-1:0];
      if (s < CMIN_S) return CMIN_S[CW-1:0];
      return s[CW-1:0];
   endfunction

   function automatic logic signed [31:0] sat_out(input logic signed [NW:0] v);
      if (v > OMAX_S) return OMAX_S[31:0];
      if (v < OMIN_S) return OMIN_S[31:0];
      return v[31:0];
   endfunction

   function automatic logic signed [NW:0] ext_c(input logic signed [CW-1:0] v);
      return $signed({{(NW+1-CW){v[CW-1]}}, v});
   endfunction

   function automatic logic [KW-1:0] clamp_cnt(input logic [KW-1:0] v);
      if (v == '0) return KW'(1);
      if (v > SEG_MAX) return SEG_MAX;
      return v;
   endfunction

   // configuration
   logic [SEG_LEN_WIDTH-1:0] seg_len_ff;
   logic [KW-1:0]            min_seg_ff, max_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_len_ff <= SEG_LEN_RESET;
         min_seg_ff <= MIN_SEG_RESET;
         max_seg_ff <= MAX_SEG_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SEGMENT_LENGTH: seg_len_ff <= csr_write_data[SEG_LEN_WIDTH-1:0];
            CSR_MIN_SEGMENTS:   min_seg_ff <= csr_write_data[KW-1:0];
            CSR_MAX_SEGMENTS:   max_seg_ff <= csr_write_data[KW-1:0];
            default: ;
         endcase
      end
   end

   // path state and captured command
   logic signed [CW-1:0] cur_x_ff, cur_y_ff, first_x_ff, first_y_ff;
   logic                 active_ff;
   logic [1:0]           mode_ff;
   logic signed [CW-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff, p3x_ff, p3y_ff;
   logic signed [CW-1:0] off_x, off_y;

   assign off_x = req_relative ? cur_x_ff : '0;
   assign off_y = req_relative ? cur_y_ff : '0;

   // leg length
   logic [1:0]           leg_idx_ff;
   logic signed [CW-1:0] pax, pay, pbx, pby;
   logic signed [CW:0]   dx, dy;
   logic [CW:0]          magx, magy;
   logic [XW-1:0]        mxe, mye, mmax, shx, shy;
   logic [4:0]           shift;
   logic [30:0]          mxs_ff, mys_ff;
   logic [4:0]           s_ff;
   logic [61:0]          sq_ff;
   logic [63:0]          v_ff, res_ff, bit_ff, trial;
   logic [4:0]           rc_ff;
   logic [LW-1:0]        len_ff;

   always_comb begin
      case (leg_idx_ff)
         2'd0: begin
            pax = cur_x_ff; pay = cur_y_ff; pbx = p1x_ff; pby = p1y_ff;
         end
         2'd1: begin
            pax = p1x_ff; pay = p1y_ff; pbx = p2x_ff; pby = p2y_ff;
         end
         default: begin
            pax = p2x_ff; pay = p2y_ff; pbx = p3x_ff; pby = p3y_ff;
         end
      endcase
      dx    = $signed({pbx[CW-1], pbx}) - $signed({pax[CW-1], pax});
      dy    = $signed({pby[CW-1], pby}) - $signed({pay[CW-1], pay});
      magx  = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
      magy  = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
      mxe   = XW'(magx);
      mye   = XW'(magy);
      mmax  = (mxe > mye) ? mxe : mye;
      shift = '0;
      for (int i = 31; i < XW; i++) begin
         if (mmax[i]) shift = 5'(i - 30);
      end
      shx   = mxe >> shift;
      shy   = mye >> shift;
      trial = res_ff + bit_ff;
   end

   // segment count
   logic [KW-1:0]            lo_cnt, hi_cnt, k_ff, n_ff;
   logic [SEG_LEN_WIDTH-1:0] seg_eff;
   logic [PW-1:0]            prod_ff;
   logic                     ge_hi, fits;

   assign lo_cnt  = clamp_cnt(min_seg_ff);
   assign hi_cnt  = clamp_cnt(max_seg_ff);
   assign seg_eff = (seg_len_ff == '0) ? SEG_LEN_WIDTH'(1) : seg_len_ff;
   assign ge_hi   = (k_ff >= hi_cnt);
   assign fits    = (prod_ff >= PW'(len_ff));

   // curve point
   logic [KW-1:0]        a_ff, b_ff, a_now;
   logic [12:0]          a2_ff, b2_ff, n2_ff;
   logic [WW-1:0]        w_ff [4];
   logic [WW-1:0]        d_ff;
   logic [1:0]           mi_ff;
   logic signed [AW-1:0] acc_ff [2];
   logic signed [CW-1:0] mcx, mcy;
   logic [NW-1:0]        u_ff [2];
   logic [WW-1:0]        rem_ff [2];
   logic                 neg_ff [2];
   logic [DCW-1:0]       dc_ff;
   logic signed [NW-1:0] num [2];
   logic [NW-1:0]        uin [2];
   logic [WW:0]          r2 [2];
   logic                 qb [2];
   logic signed [NW:0]   qres [2];

   assign a_now = n_ff - k_ff;

   always_comb begin
      case (mi_ff)
         2'd0: begin mcx = cur_x_ff; mcy = cur_y_ff; end
         2'd1: begin mcx = p1x_ff;   mcy = p1y_ff;   end
         2'd2: begin mcx = p2x_ff;   mcy = p2y_ff;   end
         default: begin mcx = p3x_ff; mcy = p3y_ff; end
      endcase
      for (int l = 0; l < 2; l++) begin
         num[l] = $signed({{(NW-AW){acc_ff[l][AW-1]}}, acc_ff[l]});
         num[l] = num[l] + $signed(NW'(d_ff >> 1));
         uin[l] = num[l][NW-1] ? (NW'(-num[l]) + NW'(d_ff) - NW'(1)) : NW'(num[l]);
         r2[l]  = {rem_ff[l], u_ff[l][NW-1]};
         qb[l]  = (r2[l] >= {1'b0, d_ff});
         qres[l] = neg_ff[l] ? -$signed({1'b0, u_ff[l]}) : $signed({1'b0, u_ff[l]});
      end
   end

   // output register
   logic rsp_valid_ff;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_err || cmd.emit_target || cmd.emit_curve) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_err) begin
         rsp_point_x <= sat_out(ext_c(cur_x_ff));
         rsp_point_y <= sat_out(ext_c(cur_y_ff));
         rsp_status  <= 1'b1;
         rsp_last    <= 1'b1;
      end else if (cmd.emit_target) begin
         rsp_point_x <= sat_out(ext_c(p3x_ff));
         rsp_point_y <= sat_out(ext_c(p3y_ff));
         rsp_status  <= 1'b0;
         rsp_last    <= 1'b1;
      end else if (cmd.emit_curve) begin
         rsp_point_x <= sat_out(qres[0]);
         rsp_point_y <= sat_out(qres[1]);
         rsp_status  <= 1'b0;
         rsp_last    <= (k_ff == n_ff);
      end
   end

   // path state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         active_ff  <= 1'b0;
      end else if (cmd.emit_target) begin
         cur_x_ff <= p3x_ff;
         cur_y_ff <= p3y_ff;
         if (mode_ff == MODE_MOVE) begin
            first_x_ff <= p3x_ff;
            first_y_ff <= p3y_ff;
            active_ff  <= 1'b1;
         end
      end else if (cmd.do_close) begin
         cur_x_ff  <= first_x_ff;
         cur_y_ff  <= first_y_ff;
         active_ff <= 1'b0;
      end else if (cmd.emit_curve && k_ff == n_ff) begin
         cur_x_ff <= p3x_ff;
         cur_y_ff <= p3y_ff;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         p1x_ff  <= abs_coord(req_ctrl1_x, off_x);
         p1y_ff  <= abs_coord(req_ctrl1_y, off_y);
         p2x_ff  <= abs_coord(req_ctrl2_x, off_x);
         p2y_ff  <= abs_coord(req_ctrl2_y, off_y);
         p3x_ff  <= abs_coord(req_target_x, off_x);
         p3y_ff  <= abs_coord(req_target_y, off_y);
      end
      if (cmd.leg_start) begin
         leg_idx_ff <= '0;
         len_ff     <= '0;
      end
      if (cmd.leg_diff) begin
         mxs_ff <= shx[30:0];
         mys_ff <= shy[30:0];
         s_ff   <= shift;
      end
      if (cmd.sq_x) begin
         sq_ff <= 62'(mxs_ff * mxs_ff);
      end
      if (cmd.sq_y) begin
         v_ff   <= 64'(sq_ff) + 64'(mys_ff * mys_ff);
         res_ff <= '0;
         bit_ff <= 64'd1 << 62;
         rc_ff  <= '0;
      end
      if (cmd.root_step) begin
         if (v_ff >= trial) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         rc_ff  <= rc_ff + 5'd1;
      end
      if (cmd.leg_acc) begin
         len_ff     <= len_ff + (LW'(res_ff[31:0]) << s_ff);
         leg_idx_ff <= leg_idx_ff + 2'd1;
      end
      if (cmd.cnt_init) begin
         k_ff    <= lo_cnt;
         prod_ff <= PW'(lo_cnt) * PW'(seg_eff);
      end
      if (cmd.cnt_step) begin
         if (ge_hi) begin
            n_ff <= hi_cnt;
            k_ff <= KW'(1);
         end else if (fits) begin
            n_ff <= k_ff;
            k_ff <= KW'(1);
         end else begin
            k_ff    <= k_ff + KW'(1);
            prod_ff <= prod_ff + PW'(seg_eff);
         end
      end
      if (cmd.w1) begin
         a_ff  <= a_now;
         b_ff  <= k_ff;
         a2_ff <= 13'(a_now * a_now);
         b2_ff <= 13'(k_ff * k_ff);
         n2_ff <= 13'(n_ff * n_ff);
      end
      if (cmd.w2) begin
         w_ff[0]   <= WW'(21'(a2_ff) * 21'(a_ff));
         w_ff[1]   <= WW'(21'(a2_ff) * 21'(b_ff) * 21'd3);
         w_ff[2]   <= WW'(21'(b2_ff) * 21'(a_ff) * 21'd3);
         w_ff[3]   <= WW'(21'(b2_ff) * 21'(b_ff));
         d_ff      <= WW'(21'(n2_ff) * 21'(n_ff));
         acc_ff[0] <= '0;
         acc_ff[1] <= '0;
         mi_ff     <= '0;
      end
      if (cmd.mac) begin
         acc_ff[0] <= acc_ff[0] + AW'($signed({1'b0, w_ff[mi_ff]}) * mcx);
         acc_ff[1] <= acc_ff[1] + AW'($signed({1'b0, w_ff[mi_ff]}) * mcy);
         mi_ff     <= mi_ff + 2'd1;
      end
      if (cmd.div_init) begin
         for (int l = 0; l < 2; l++) begin
            u_ff[l]   <= uin[l];
            neg_ff[l] <= num[l][NW-1];
            rem_ff[l] <= '0;
         end
         dc_ff <= '0;
      end
      if (cmd.div_step) begin
         for (int l = 0; l < 2; l++) begin
            rem_ff[l] <= qb[l] ? WW'(r2[l] - {1'b0, d_ff}) : r2[l][WW-1:0];
            u_ff[l]   <= {u_ff[l][NW-2:0], qb[l]};
         end
         dc_ff <= dc_ff + DCW'(1);
      end
      if (cmd.emit_curve && k_ff != n_ff) begin
         k_ff <= k_ff + KW'(1);
      end
   end

   always_comb begin
      sts.mode      = mode_ff;
      sts.active    = active_ff;
      sts.out_free  = out_free;
      sts.root_done = (rc_ff == 5'd31);
      sts.leg_last  = (leg_idx_ff == 2'd2);
      sts.cnt_done  = ge_hi || fits;
      sts.mac_last  = (mi_ff == 2'd3);
      sts.div_done  = (dc_ff == DIV_LAST);
      sts.pt_last   = (k_ff == n_ff);
   end

endmodule

`default_nettype wire

/* rtl/core/cubic_bezier_flattener_core.sv */
// Move and line: the target becomes the result once the output register is free.
// Close: no result. No open contour: non-move modes return current point, status 1.
// Cubic: three legs (square-root unit, 2 bits per step), then a segment-count search,
// then per point: weights, 4-step multiply-accumulate and a 1-bit-per-cycle divider.
// One command at a time; a result waits in the output register while the next is taken.
// Synchronous active-high reset clears state to zero and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_flattener_core
   import cbf_pkg::*;
#(
   parameter int COORD_WIDTH   = 32,
   parameter int SEGMENT_LIMIT = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_mode,
   input  wire logic                 req_relative,
   input  wire logic signed [31:0]   req_ctrl1_x,
   input  wire logic signed [31:0]   req_ctrl1_y,
   input  wire logic signed [31:0]   req_ctrl2_x,
   input  wire logic signed [31:0]   req_ctrl2_y,
   input  wire logic signed [31:0]   req_target_x,
   input  wire logic signed [31:0]   req_target_y,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [31:0]        rsp_point_x,
   output logic signed [31:0]        rsp_point_y,
   output logic                      rsp_status,
   output logic                      rsp_last,
   input  wire logic                 csr_write_enable,
   input  wire logic [1:0]           csr_index,
   input  wire logic [CSR_WIDTH-1:0] csr_write_data
);

   cmd_type cmd;
   sts_type sts;

   cbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cbf_datapath #(
      .CW            (COORD_WIDTH),
      .SEGMENT_LIMIT (SEGMENT_LIMIT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_relative     (req_relative),
      .req_ctrl1_x      (req_ctrl1_x),
      .req_ctrl1_y      (req_ctrl1_y),
      .req_ctrl2_x      (req_ctrl2_x),
      .req_ctrl2_y      (req_ctrl2_y),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule

`default_nettype wire

/* tb/sv/cubic_bezier_flattener_core_tb.sv */
`timescale 1ns / 1ps

module cubic_bezier_flattener_core_tb;
   import cbf_pkg::*;

   localparam longint C32_MAX = 64'sd2147483647;
   localparam longint C32_MIN = -64'sd2147483648;
   localparam int     CYCLE_LIMIT = 10000000;
   localparam int     RANDOM_ITEMS = 260;

   typedef struct {
      logic [1:0]         mode;
      logic               rel;
      logic signed [31:0] c1x, c1y, c2x, c2y, tx, ty;
   } path_cmd_t;

   typedef struct {
      logic signed [31:0] px, py;
      logic               status;
      logic               last;
   } point_t;

   typedef struct {
      path_cmd_t cmd;
      bit        typed;
      point_t    pt;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = MODE_MOVE;
   logic req_relative = 1'b0;
   logic signed [31:0] req_ctrl1_x = '0, req_ctrl1_y = '0, req_ctrl2_x = '0;
   logic signed [31:0] req_ctrl2_y = '0, req_target_x = '0, req_target_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_point_x, rsp_point_y;
   logic rsp_status, rsp_last;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = CSR_SEGMENT_LENGTH;
   logic [CSR_WIDTH-1:0] csr_write_data = '0;

   cubic_bezier_flattener_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_mode), .req_relative(req_relative),
      .req_ctrl1_x(req_ctrl1_x), .req_ctrl1_y(req_ctrl1_y),
      .req_ctrl2_x(req_ctrl2_x), .req_ctrl2_y(req_ctrl2_y),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_status(rsp_status), .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   longint cur_x, cur_y, first_x, first_y;
   bit     contour_on;
   logic [30:0] seg_len_r;
   logic [6:0]  min_seg_r, max_seg_r;

   point_t pending_points[$];
   row_t   rows[$];
   int     errors = 0;
   int     cycles = 0;
   int     send_idle_pct = 0;
   int     stall_pct = 0;

   function automatic longint sat32(input longint v);
      if (v > C32_MAX) return C32_MAX;
      if (v < C32_MIN) return C32_MIN;
      return v;
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return v < 0 ? 64'd0 - longint'(v) : longint'(v);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned leg_length(input longint ax, ay, bx, by);
      longint unsigned mx, my, m;
      int s;
      mx = magnitude(bx - ax);
      my = magnitude(by - ay);
      m = mx > my ? mx : my;
      s = 0;
      while ((m >> s) >= (64'd1 << 31)) s++;
      mx >>= s;
      my >>= s;
      return int_sqrt(mx * mx + my * my) << s;
   endfunction

   function automatic longint blend(input longint c0, c1, c2, c3,
                                    input longint w0, w1, w2, w3, input longint d);
      longint c[4], w[4];
      longint whole, rem, q, r;
      c[0] = c0; c[1] = c1; c[2] = c2; c[3] = c3;
      w[0] = w0; w[1] = w1; w[2] = w2; w[3] = w3;
      whole = 0;
      rem = 0;
      for (int i = 0; i < 4; i++) begin
         q = c[i] / d;
         r = c[i] % d;
         if (r < 0) begin
            r += d;
            q -= 1;
         end
         whole += w[i] * q;
         rem += w[i] * r;
      end
      return whole + (2 * rem + d) / (2 * d);
   endfunction

   function automatic longint unsigned clamp_count(input longint unsigned v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return v;
   endfunction

   function automatic point_t mk_point(input longint x, y, input logic st, lst);
      point_t p;
      p.px = sat32(x);
      p.py = sat32(y);
      p.status = st;
      p.last = lst;
      return p;
   endfunction

   task automatic predict_command(input path_cmd_t c);
      longint ox, oy, ax, ay, bx, by, tx, ty, d, a, b;
      longint unsigned len, seg, n, lo, hi;
      int cnt;
      ox = c.rel ? cur_x : 0;
      oy = c.rel ? cur_y : 0;
      ax = sat32(longint'(c.c1x) + ox);
      ay = sat32(longint'(c.c1y) + oy);
      bx = sat32(longint'(c.c2x) + ox);
      by = sat32(longint'(c.c2y) + oy);
      tx = sat32(longint'(c.tx) + ox);
      ty = sat32(longint'(c.ty) + oy);
      if (c.mode != MODE_MOVE && !contour_on) begin
         pending_points.push_back(mk_point(cur_x, cur_y, 1'b1, 1'b1));
      end else if (c.mode == MODE_MOVE || c.mode == MODE_LINE) begin
         if (c.mode == MODE_MOVE) begin
            first_x = tx;
            first_y = ty;
            contour_on = 1'b1;
         end
         cur_x = tx;
         cur_y = ty;
         pending_points.push_back(mk_point(tx, ty, 1'b0, 1'b1));
      end else if (c.mode == MODE_CLOSE) begin
         cur_x = first_x;
         cur_y = first_y;
         contour_on = 1'b0;
      end else begin
         len = leg_length(cur_x, cur_y, ax, ay) + leg_length(ax, ay, bx, by)
             + leg_length(bx, by, tx, ty);
         seg = seg_len_r == 0 ? 1 : seg_len_r;
         n = len / seg + ((len % seg) != 0 ? 1 : 0);
         lo = clamp_count(min_seg_r);
         hi = clamp_count(max_seg_r);
         if (n < lo) n = lo;
         if (n > hi) n = hi;
         cnt = int'(n);
         d = longint'(n) * longint'(n) * longint'(n);
         for (int k = 1; k <= cnt; k++) begin
            a = cnt - k;
            b = k;
            pending_points.push_back(mk_point(
               blend(cur_x, ax, bx, tx, a * a * a, 3 * a * a * b, 3 * a * b * b, b * b * b, d),
               blend(cur_y, ay, by, ty, a * a * a, 3 * a * a * b, 3 * a * b * b, b * b * b, d),
               1'b0, k == cnt));
         end
         cur_x = tx;
         cur_y = ty;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      point_t e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("Mismatches found");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $display("%0t unexpected result x=%h y=%h", $time, rsp_point_x, rsp_point_y);
            errors++;
         end else begin
            e = pending_points.pop_front();
            if (rsp_point_x !== e.px || rsp_point_y !== e.py || rsp_status !== e.status
                || rsp_last !== e.last) begin
               $display("%0t mismatch exp x=%h y=%h st=%b last=%b act x=%h y=%h st=%b last=%b",
                        $time, e.px, e.py, e.status, e.last,
                        rsp_point_x, rsp_point_y, rsp_status, rsp_last);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_command(input path_cmd_t c, input bit typed, input point_t pt);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode = c.mode;
      req_relative = c.rel;
      req_ctrl1_x = c.c1x;
      req_ctrl1_y = c.c1y;
      req_ctrl2_x = c.c2x;
      req_ctrl2_y = c.c2y;
      req_target_x = c.tx;
      req_target_y = c.ty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_command(c);
      if (typed) pending_points[$] = pt;
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [30:0] val);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = val;
      if (idx == CSR_SEGMENT_LENGTH) seg_len_r = val;
      else if (idx == CSR_MIN_SEGMENTS) min_seg_r = val[6:0];
      else if (idx == CSR_MAX_SEGMENTS) max_seg_r = val[6:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic add_row(input logic [1:0] m, input logic r,
                          input logic signed [31:0] c1x, c1y, c2x, c2y, tx, ty,
                          input bit typed, input logic signed [31:0] px, py,
                          input logic st);
      row_t w;
      w.cmd.mode = m; w.cmd.rel = r;
      w.cmd.c1x = c1x; w.cmd.c1y = c1y; w.cmd.c2x = c2x; w.cmd.c2y = c2y;
      w.cmd.tx = tx; w.cmd.ty = ty;
      w.typed = typed;
      w.pt.px = px; w.pt.py = py; w.pt.status = st; w.pt.last = 1'b1;
      rows.push_back(w);
   endtask

   function automatic logic signed [31:0] rand_coord;
      case ($urandom_range(9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(3))
               0: return 32'sh7fffffff;
               1: return 32'sh80000000;
               2: return 32'sh0;
               default: return -32'sd1;
            endcase
         end
         default: return $signed($urandom_range(32'h3fffff)) - 32'sd2097152;
      endcase
   endfunction

   function automatic path_cmd_t rand_cmd(input logic [1:0] m);
      path_cmd_t c;
      c.mode = m;
      c.rel = 1'($urandom_range(1));
      c.c1x = rand_coord(); c.c1y = rand_coord();
      c.c2x = rand_coord(); c.c2y = rand_coord();
      c.tx = rand_coord(); c.ty = rand_coord();
      return c;
   endfunction

   logic [30:0] seg_set[5] = '{31'd524288, 31'd0, 31'h7fffffff, 31'd131072, 31'd1};
   logic [6:0]  min_set[5] = '{7'd4, 7'd1, 7'd64, 7'd0, 7'd2};
   logic [6:0]  max_set[5] = '{7'd48, 7'd64, 7'd1, 7'd127, 7'd8};

   initial begin
      point_t none;
      int sent, segs;
      none = mk_point(0, 0, 1'b0, 1'b0);
      cur_x = 0; cur_y = 0; first_x = 0; first_y = 0;
      contour_on = 1'b0;
      seg_len_r = SEG_LEN_RESET;
      min_seg_r = MIN_SEG_RESET;
      max_seg_r = MAX_SEG_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(MODE_LINE, 0, 0, 0, 0, 0, 5, 5, 1, 0, 0, 1);
      add_row(MODE_CUBIC, 1, 1, 2, 3, 4, 5, 6, 1, 0, 0, 1);
      add_row(MODE_CLOSE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1);
      add_row(MODE_MOVE, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 1,
              32'sh80000000, 32'sh7fffffff, 0);
      add_row(MODE_LINE, 1, 0, 0, 0, 0, -32'sd1, -32'sd1, 1,
              32'sh80000000, 32'sh7ffffffe, 0);
      add_row(MODE_LINE, 0, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 1,
              32'sh7fffffff, 32'sh80000000, 0);
      add_row(MODE_CUBIC, 0, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0);
      add_row(MODE_CUBIC, 1, 32'sh7fffffff, 32'sh00010000, -32'sd65536, 32'sh80000000,
              32'sh00123456, -32'sd7, 0, 0, 0, 0);
      add_row(MODE_CLOSE, 1, 5, 5, 5, 5, 5, 5, 0, 0, 0, 0);
      add_row(MODE_MOVE, 1, 0, 0, 0, 0, 32'sh00030000, -32'sd196608, 0, 0, 0, 0);
      add_row(MODE_CUBIC, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_CUBIC, 0, 32'sh00100000, 32'sh00200000, -32'sd3000000, 32'sh00050000,
              32'sh00080000, -32'sd1, 0, 0, 0, 0);
      add_row(MODE_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_LINE, 0, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0);
      add_row(MODE_MOVE, 0, 0, 0, 0, 0, 32'sh00010000, 32'sh00010000, 1,
              32'sh00010000, 32'sh00010000, 0);
      add_row(MODE_MOVE, 1, 0, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 1,
              32'sh7fffffff, 32'sh7fffffff, 0);

      foreach (rows[i]) send_command(rows[i].cmd, rows[i].typed, rows[i].pt);
      drain();

      sent = 0;
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(CSR_SEGMENT_LENGTH, seg_set[ph]);
         csr_write(CSR_MIN_SEGMENTS, {24'd0, min_set[ph]});
         csr_write(CSR_MAX_SEGMENTS, {24'd0, max_set[ph]});
         if (ph == 4) csr_write(2'd3, 31'($urandom));
         while (sent < RANDOM_ITEMS * (ph + 1) / 5) begin
            if (sent < RANDOM_ITEMS / 3) begin
               send_idle_pct = 32; stall_pct = 88;
            end else if (sent < 2 * RANDOM_ITEMS / 3) begin
               send_idle_pct = 88; stall_pct = 32;
            end else begin
               send_idle_pct = 0; stall_pct = 0;
            end
            if ($urandom_range(99) < 80) begin
               send_command(rand_cmd(MODE_MOVE), 0, none);
               sent++;
               segs = $urandom_range(1, 4);
               repeat (segs) begin
                  send_command(rand_cmd($urandom_range(99) < 60 ? MODE_CUBIC : MODE_LINE),
                               0, none);
                  sent++;
               end
               if ($urandom_range(99) < 70) begin
                  send_command(rand_cmd(MODE_CLOSE), 0, none);
                  sent++;
               end
            end else begin
               send_command(rand_cmd(2'($urandom_range(3))), 0, none);
               sent++;
            end
            if (sent == RANDOM_ITEMS / 2) drain();
         end
         drain();
      end

      repeat (100) @(posedge clock);
      if (errors == 0 && pending_points.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
